// ===== rtl/tsas_pkg.sv =====
// Package of shared constants, codes and types for the touch sample average sequencer.
package tsas_pkg;

  localparam int SAMPLES  = 4;
  localparam int SAMPLE_W = 12;
  localparam int SHIFT    = $clog2(SAMPLES);
  localparam int SUM_W    = SAMPLE_W + SHIFT;
  localparam int CNT_W    = $clog2(SAMPLES) + 1;
  localparam int TICK_W   = 16;
  localparam int KIND_W   = 2;
  localparam int ACT_W    = 2;

  localparam logic [KIND_W-1:0] KIND_PEN  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CONV = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TICK = 2'd2;

  localparam logic [ACT_W-1:0] ACT_NONE    = 2'd0;
  localparam logic [ACT_W-1:0] ACT_CONVERT = 2'd1;
  localparam logic [ACT_W-1:0] ACT_WAIT    = 2'd2;

  localparam logic [TICK_W-1:0] REPEAT_TICKS_RESET = 16'd1;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [SAMPLE_W-1:0] x_sample;
    logic [SAMPLE_W-1:0] y_sample;
    logic                x_pen_up;
    logic                y_pen_up;
  } evt_t;

  typedef struct packed {
    logic                report_valid;
    logic                pressed;
    logic                position_valid;
    logic [SAMPLE_W-1:0] x_position;
    logic [SAMPLE_W-1:0] y_position;
    logic [ACT_W-1:0]    action;
  } res_t;

  typedef struct packed {
    logic [CNT_W-1:0]  sample_count;
    logic [SUM_W-1:0]  x_sum;
    logic [SUM_W-1:0]  y_sum;
    logic [TICK_W-1:0] repeat_countdown;
    logic              repeat_armed;
  } state_t;

endpackage

// ===== rtl/tsas_evt_if.sv =====
// Event channel interface carrying one panel event per transfer.
interface tsas_evt_if;
  logic                             valid;
  logic                             ready;
  logic [tsas_pkg::KIND_W-1:0]      kind;
  logic [tsas_pkg::SAMPLE_W-1:0]    x_sample;
  logic [tsas_pkg::SAMPLE_W-1:0]    y_sample;
  logic                             x_pen_up;
  logic                             y_pen_up;

  modport source (output valid, kind, x_sample, y_sample, x_pen_up, y_pen_up, input ready);
  modport sink (input valid, kind, x_sample, y_sample, x_pen_up, y_pen_up, output ready);
endinterface

// ===== rtl/tsas_res_if.sv =====
// Result channel interface carrying one report and action per transfer.
interface tsas_res_if;
  logic                          valid;
  logic                          ready;
  logic                          report_valid;
  logic                          pressed;
  logic                          position_valid;
  logic [tsas_pkg::SAMPLE_W-1:0] x_position;
  logic [tsas_pkg::SAMPLE_W-1:0] y_position;
  logic [tsas_pkg::ACT_W-1:0]    action;

  modport source (output valid, report_valid, pressed, position_valid, x_position,
                  y_position, action, input ready);
  modport sink (input valid, report_valid, pressed, position_valid, x_position,
                y_position, action, output ready);
endinterface

// ===== rtl/tsas_step.sv =====
// Combinational sequencing step: result and next state for one event.
module tsas_step (
  input  tsas_pkg::evt_t                  evt,
  input  tsas_pkg::state_t                state,
  input  logic [tsas_pkg::TICK_W-1:0]     repeat_ticks,
  output tsas_pkg::res_t                  res,
  output tsas_pkg::state_t                state_next
);

  logic                          both_up;
  logic                          both_down;
  logic [tsas_pkg::SUM_W-1:0]    x_acc;
  logic [tsas_pkg::SUM_W-1:0]    y_acc;
  logic [tsas_pkg::CNT_W-1:0]    count_inc;
  logic                          burst_done;

  assign both_up    = evt.x_pen_up & evt.y_pen_up;
  assign both_down  = ~evt.x_pen_up & ~evt.y_pen_up;
  assign x_acc      = state.x_sum + tsas_pkg::SUM_W'(evt.x_sample);
  assign y_acc      = state.y_sum + tsas_pkg::SUM_W'(evt.y_sample);
  assign count_inc  = state.sample_count + tsas_pkg::CNT_W'(1);
  assign burst_done = count_inc >= tsas_pkg::CNT_W'(tsas_pkg::SAMPLES);

  always_comb begin
    res        = '0;
    state_next = state;
    case (evt.kind)
      tsas_pkg::KIND_PEN: begin
        if (both_up) begin
          res.report_valid = 1'b1;
          res.action       = tsas_pkg::ACT_WAIT;
        end else if (both_down) begin
          res.action = tsas_pkg::ACT_CONVERT;
        end
      end
      tsas_pkg::KIND_CONV: begin
        if (both_up) begin
          state_next.sample_count = '0;
          state_next.x_sum        = '0;
          state_next.y_sum        = '0;
          res.report_valid        = 1'b1;
          res.action              = tsas_pkg::ACT_WAIT;
        end else if (burst_done) begin
          res.report_valid            = 1'b1;
          res.pressed                 = 1'b1;
          res.position_valid          = 1'b1;
          res.x_position              = x_acc[tsas_pkg::SUM_W-1:tsas_pkg::SHIFT];
          res.y_position              = y_acc[tsas_pkg::SUM_W-1:tsas_pkg::SHIFT];
          res.action                  = tsas_pkg::ACT_WAIT;
          state_next.sample_count     = '0;
          state_next.x_sum            = '0;
          state_next.y_sum            = '0;
          state_next.repeat_countdown = repeat_ticks;
          state_next.repeat_armed     = 1'b1;
        end else begin
          state_next.sample_count = count_inc;
          state_next.x_sum        = x_acc;
          state_next.y_sum        = y_acc;
          res.action              = tsas_pkg::ACT_CONVERT;
        end
      end
      tsas_pkg::KIND_TICK: begin
        if (state.repeat_armed) begin
          if (state.repeat_countdown <= tsas_pkg::TICK_W'(1)) begin
            state_next.repeat_countdown = '0;
            state_next.repeat_armed     = 1'b0;
            if (both_up) begin
              res.report_valid = 1'b1;
              res.action       = tsas_pkg::ACT_WAIT;
            end else begin
              res.action = tsas_pkg::ACT_CONVERT;
            end
          end else begin
            state_next.repeat_countdown = state.repeat_countdown - tsas_pkg::TICK_W'(1);
          end
        end
      end
      default: begin
        res = '0;
      end
    endcase
  end

endmodule

// ===== rtl/touch_sample_average_sequencer_unit.sv =====
// Top level of the touch sample average sequencer with input and result registers.
// Events pass the input register, then the result register: a two-stage pipe.
// Throughput: one event per cycle while the result side does not stall.
// The burst and repeat state is updated as an event moves into the result register.
// Reset (rst, synchronous, active high) clears both pipe stages and all sequencing state.
// After reset repeat_ticks holds 1.
module touch_sample_average_sequencer_unit (
  input  logic                            clk,
  input  logic                            rst,
  tsas_evt_if.sink                        evt,
  tsas_res_if.source                      res,
  input  logic                            cfg_we,
  input  logic [tsas_pkg::TICK_W-1:0]     cfg_data
);

  logic                          in_valid;
  tsas_pkg::evt_t                in_item;
  logic                          out_valid;
  tsas_pkg::res_t                out_item;
  tsas_pkg::state_t              state;
  tsas_pkg::state_t              state_next;
  tsas_pkg::res_t                step_res;
  logic [tsas_pkg::TICK_W-1:0]   repeat_ticks;
  logic                          advance;
  tsas_pkg::evt_t                evt_item;

  assign evt_item = '{kind: evt.kind, x_sample: evt.x_sample, y_sample: evt.y_sample,
                      x_pen_up: evt.x_pen_up, y_pen_up: evt.y_pen_up};

  assign advance   = in_valid & (~out_valid | res.ready);
  assign evt.ready = ~in_valid | advance;

  tsas_step u_step (
    .evt          (in_item),
    .state        (state),
    .repeat_ticks (repeat_ticks),
    .res          (step_res),
    .state_next   (state_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      repeat_ticks <= tsas_pkg::REPEAT_TICKS_RESET;
    end else if (cfg_we) begin
      repeat_ticks <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (evt.ready) begin
      in_valid <= evt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (evt.valid && evt.ready) begin
      in_item <= evt_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      state     <= '0;
    end else if (advance) begin
      out_valid <= 1'b1;
      state     <= state_next;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= step_res;
    end
  end

  assign res.valid          = out_valid;
  assign res.report_valid   = out_item.report_valid;
  assign res.pressed        = out_item.pressed;
  assign res.position_valid = out_item.position_valid;
  assign res.x_position     = out_item.x_position;
  assign res.y_position     = out_item.y_position;
  assign res.action         = out_item.action;

  a_count_in_range: assert property (@(posedge clk) disable iff (rst)
    state.sample_count < tsas_pkg::CNT_W'(tsas_pkg::SAMPLES))
    else $error("sample count reached the burst length");

  a_disarmed_zero: assert property (@(posedge clk) disable iff (rst)
    !state.repeat_armed |-> state.repeat_countdown == '0)
    else $error("repeat countdown non-zero while disarmed");

  a_position_is_press: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.position_valid |->
      out_item.report_valid && out_item.pressed && out_item.action == tsas_pkg::ACT_WAIT)
    else $error("position result without a pressed report");

  a_advance_fills_out: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("result register empty after an event moved on");

  a_stall_holds_input: assert property (@(posedge clk) disable iff (rst)
    in_valid && !advance |=> in_valid && $stable(in_item))
    else $error("held event lost while the result side stalled");

endmodule

// ===== sim/touch_sample_average_sequencer_unit_test.sv =====
// Self-checking testbench for the touch sample average sequencer with a built-in predictor.
module touch_sample_average_sequencer_unit_test;

  localparam logic [tsas_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int PHASE_ITEMS = 165;
  localparam int PRESSURE_AT = 300;
  localparam int PRESSURE_CYCLES = 150;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we;
  logic [tsas_pkg::TICK_W-1:0] cfg_data;

  tsas_evt_if evt_ch ();
  tsas_res_if res_ch ();

  touch_sample_average_sequencer_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .evt      (evt_ch),
    .res      (res_ch),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  tsas_pkg::evt_t pending_events[$];
  tsas_pkg::res_t expected_reports[$];
  int fail_count = 0;
  int accepted_events = 0;
  bit no_idle = 1'b0;

  // Predictor state and its copy of the register.
  logic [tsas_pkg::CNT_W-1:0]  burst_count;
  logic [tsas_pkg::SUM_W-1:0]  burst_x_sum;
  logic [tsas_pkg::SUM_W-1:0]  burst_y_sum;
  logic [tsas_pkg::TICK_W-1:0] repeat_left;
  logic                        repeat_pending;
  logic [tsas_pkg::TICK_W-1:0] tick_setting;

  function automatic tsas_pkg::res_t advance_touch(input tsas_pkg::evt_t e);
    tsas_pkg::res_t r;
    logic both_up;
    r = '0;
    both_up = e.x_pen_up && e.y_pen_up;
    case (e.kind)
      tsas_pkg::KIND_PEN: begin
        if (both_up) begin
          r.report_valid = 1'b1;
          r.action = tsas_pkg::ACT_WAIT;
        end else if (!e.x_pen_up && !e.y_pen_up) begin
          r.action = tsas_pkg::ACT_CONVERT;
        end
      end
      tsas_pkg::KIND_CONV: begin
        if (both_up) begin
          burst_count = '0;
          burst_x_sum = '0;
          burst_y_sum = '0;
          r.report_valid = 1'b1;
          r.action = tsas_pkg::ACT_WAIT;
        end else begin
          burst_x_sum = burst_x_sum + tsas_pkg::SUM_W'(e.x_sample);
          burst_y_sum = burst_y_sum + tsas_pkg::SUM_W'(e.y_sample);
          burst_count = burst_count + 1'b1;
          if (burst_count >= tsas_pkg::SAMPLES) begin
            r.report_valid = 1'b1;
            r.pressed = 1'b1;
            r.position_valid = 1'b1;
            r.x_position = tsas_pkg::SAMPLE_W'(burst_x_sum / tsas_pkg::SAMPLES);
            r.y_position = tsas_pkg::SAMPLE_W'(burst_y_sum / tsas_pkg::SAMPLES);
            r.action = tsas_pkg::ACT_WAIT;
            burst_count = '0;
            burst_x_sum = '0;
            burst_y_sum = '0;
            repeat_left = tick_setting;
            repeat_pending = 1'b1;
          end else begin
            r.action = tsas_pkg::ACT_CONVERT;
          end
        end
      end
      tsas_pkg::KIND_TICK: begin
        if (repeat_pending) begin
          if (repeat_left <= 1) begin
            repeat_left = '0;
            repeat_pending = 1'b0;
            if (both_up) begin
              r.report_valid = 1'b1;
              r.action = tsas_pkg::ACT_WAIT;
            end else begin
              r.action = tsas_pkg::ACT_CONVERT;
            end
          end else begin
            repeat_left = repeat_left - 1'b1;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic tsas_pkg::evt_t make_evt(input logic [tsas_pkg::KIND_W-1:0] kind,
                                              input int unsigned xs, input int unsigned ys,
                                              input bit xu, input bit yu);
    tsas_pkg::evt_t e;
    e.kind = kind;
    e.x_sample = tsas_pkg::SAMPLE_W'(xs);
    e.y_sample = tsas_pkg::SAMPLE_W'(ys);
    e.x_pen_up = xu;
    e.y_pen_up = yu;
    return e;
  endfunction

  function automatic int unsigned rand_sample();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 0;
    if (r == 1) return 4095;
    return $urandom_range(0, 4095);
  endfunction

  function automatic int gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Driver: presents queued events and predicts each one as it transfers.
  tsas_pkg::evt_t cur_evt;
  int send_gap;

  always @(posedge clk) begin
    if (rst) begin
      evt_ch.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (evt_ch.valid && evt_ch.ready) begin
        expected_reports.push_back(advance_touch(cur_evt));
        accepted_events <= accepted_events + 1;
      end
      if (!evt_ch.valid || evt_ch.ready) begin
        if (send_gap > 0) begin
          send_gap = send_gap - 1;
          evt_ch.valid <= 1'b0;
        end else if (pending_events.size() > 0) begin
          cur_evt = pending_events.pop_front();
          evt_ch.kind <= cur_evt.kind;
          evt_ch.x_sample <= cur_evt.x_sample;
          evt_ch.y_sample <= cur_evt.y_sample;
          evt_ch.x_pen_up <= cur_evt.x_pen_up;
          evt_ch.y_pen_up <= cur_evt.y_pen_up;
          evt_ch.valid <= 1'b1;
          send_gap = gap_len();
        end else begin
          evt_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, so that the block fills up and refuses events.
  int hold_left;
  bit pressure_done;

  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      pressure_done <= 1'b0;
    end else if (!pressure_done && accepted_events >= PRESSURE_AT) begin
      hold_left <= PRESSURE_CYCLES;
      pressure_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // Monitor: compares each result transfer with the oldest expected report.
  int stall_left;
  tsas_pkg::res_t want;

  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (expected_reports.size() == 0) begin
          $error("result transfer with no report expected");
          fail_count++;
        end else begin
          want = expected_reports.pop_front();
          check_field("report_valid", want.report_valid, res_ch.report_valid);
          check_field("pressed", want.pressed, res_ch.pressed);
          check_field("position_valid", want.position_valid, res_ch.position_valid);
          check_field("x_position", want.x_position, res_ch.x_position);
          check_field("y_position", want.y_position, res_ch.y_position);
          check_field("action", want.action, res_ch.action);
        end
      end
      if (hold_left != 0) begin
        res_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left = stall_left - 1;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
        stall_left = gap_len();
      end
    end
  end

  // Sampled between edges, so that the driver's queue and valid agree.
  task automatic wait_drained();
    @(negedge clk);
    while (pending_events.size() != 0 || evt_ch.valid || expected_reports.size() != 0)
      @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_repeat_ticks(input logic [tsas_pkg::TICK_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= value;
    tick_setting = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic bit [1:0] conv_flags();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return 2'b11;
    if (r == 1) return 2'b10;
    if (r == 2) return 2'b01;
    return 2'b00;
  endfunction

  // One touch: pen down, one or more bursts of SAMPLES conversions, each followed by ticks.
  task automatic add_session(input int unsigned ticks);
    int unsigned bursts;
    bit [1:0] f;
    bursts = $urandom_range(1, 3);
    pending_events.push_back(make_evt(tsas_pkg::KIND_PEN, rand_sample(), rand_sample(),
                                      1'b0, 1'b0));
    repeat (bursts) begin
      repeat (tsas_pkg::SAMPLES) begin
        f = conv_flags();
        pending_events.push_back(make_evt(tsas_pkg::KIND_CONV, rand_sample(), rand_sample(),
                                          f[1], f[0]));
      end
      repeat (ticks) begin
        f = ($urandom_range(0, 3) == 0) ? 2'b11 : 2'($urandom_range(0, 3));
        pending_events.push_back(make_evt(tsas_pkg::KIND_TICK, rand_sample(), rand_sample(),
                                          f[1], f[0]));
      end
    end
  endtask

  task automatic add_random_phase(input int unsigned count);
    int unsigned ticks;
    int unsigned target;
    ticks = (tick_setting == 0) ? 1 : ((tick_setting > 10) ? 6 : tick_setting);
    target = pending_events.size() + count;
    while (pending_events.size() < target) begin
      if ($urandom_range(0, 9) < 7) begin
        add_session(ticks + $urandom_range(0, 1));
      end else begin
        repeat ($urandom_range(1, 3))
          pending_events.push_back(make_evt(2'($urandom_range(0, 3)), $urandom_range(0, 4095),
                                            $urandom_range(0, 4095), 1'($urandom),
                                            1'($urandom)));
      end
    end
  endtask

  logic [tsas_pkg::TICK_W-1:0] phase_ticks[6] = '{16'd0, 16'd3, 16'd65535, 16'd2, 16'd1,
                                                  16'd7};

  initial begin
    evt_ch.valid = 1'b0;
    evt_ch.kind = tsas_pkg::KIND_PEN;
    evt_ch.x_sample = '0;
    evt_ch.y_sample = '0;
    evt_ch.x_pen_up = 1'b0;
    evt_ch.y_pen_up = 1'b0;
    res_ch.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_data = '0;
    burst_count = '0;
    burst_x_sum = '0;
    burst_y_sum = '0;
    repeat_left = '0;
    repeat_pending = 1'b0;
    tick_setting = tsas_pkg::REPEAT_TICKS_RESET;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed events with the register at its reset value.
    pending_events.push_back(make_evt(tsas_pkg::KIND_PEN, 0, 0, 1'b1, 1'b1));
    pending_events.push_back(make_evt(tsas_pkg::KIND_PEN, 4095, 4095, 1'b0, 1'b0));
    pending_events.push_back(make_evt(tsas_pkg::KIND_PEN, 0, 4095, 1'b1, 1'b0));
    pending_events.push_back(make_evt(tsas_pkg::KIND_PEN, 4095, 0, 1'b0, 1'b1));
    pending_events.push_back(make_evt(KIND_UNUSED, 4095, 4095, 1'b1, 1'b1));
    pending_events.push_back(make_evt(tsas_pkg::KIND_TICK, 0, 0, 1'b0, 1'b0));
    pending_events.push_back(make_evt(tsas_pkg::KIND_CONV, 100, 200, 1'b0, 1'b0));
    pending_events.push_back(make_evt(tsas_pkg::KIND_CONV, 300, 400, 1'b0, 1'b0));
    pending_events.push_back(make_evt(tsas_pkg::KIND_CONV, 4095, 4095, 1'b1, 1'b1));
    pending_events.push_back(make_evt(tsas_pkg::KIND_CONV, 4095, 4095, 1'b1, 1'b0));
    pending_events.push_back(make_evt(tsas_pkg::KIND_CONV, 4095, 4095, 1'b0, 1'b1));
    pending_events.push_back(make_evt(tsas_pkg::KIND_CONV, 4095, 4095, 1'b0, 1'b0));
    pending_events.push_back(make_evt(tsas_pkg::KIND_CONV, 4095, 4095, 1'b0, 1'b0));
    pending_events.push_back(make_evt(tsas_pkg::KIND_TICK, 0, 0, 1'b0, 1'b0));
    pending_events.push_back(make_evt(tsas_pkg::KIND_CONV, 1, 0, 1'b0, 1'b0));
    pending_events.push_back(make_evt(tsas_pkg::KIND_CONV, 2, 0, 1'b0, 1'b0));
    pending_events.push_back(make_evt(tsas_pkg::KIND_CONV, 3, 0, 1'b0, 1'b0));
    pending_events.push_back(make_evt(tsas_pkg::KIND_CONV, 5, 0, 1'b0, 1'b0));
    pending_events.push_back(make_evt(tsas_pkg::KIND_TICK, 4095, 4095, 1'b1, 1'b1));
    pending_events.push_back(make_evt(tsas_pkg::KIND_TICK, 0, 0, 1'b1, 1'b1));
    wait_drained();

    for (int p = 0; p < 6; p++) begin
      write_repeat_ticks(phase_ticks[p]);
      no_idle = (p % 3 == 2);
      add_random_phase(PHASE_ITEMS);
      wait_drained();
    end

    repeat (20) @(posedge clk);
    if (fail_count == 0 && expected_reports.size() == 0) begin
      $display("[touch_sample_average_sequencer_unit] OK");
    end else begin
      $display("[touch_sample_average_sequencer_unit] ERROR");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("[touch_sample_average_sequencer_unit] ERROR");
    $finish;
  end

endmodule
